// ===== rtl/pcn_pkg.sv =====
// shared types, constants and helper functions for the polygon centroid block
package pcn_pkg;

  localparam int CoordW = 16;
  localparam int NormW  = 43;
  localparam int AreaW  = 42;
  localparam int MomW   = 60;
  localparam int SumW   = 25;
  localparam int ThrW   = 40;
  localparam int DivW   = 64;
  localparam int DataInW  = 48;
  localparam int DataOutW = 56;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t vz;
    coord_t vy;
    coord_t vx;
    logic   last;
  } vtx_t;

  typedef enum logic [1:0] {
    ST_AREA  = 2'd0,
    ST_AVG   = 2'd1,
    ST_FIRST = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  typedef struct packed {
    coord_t  cz;
    coord_t  cy;
    coord_t  cx;
    status_e status;
  } res_t;

  typedef enum logic {
    REG_AREA_THR = 1'b0,
    REG_NORM_THR = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_E1, S_E2, S_PICK, S_SEL, S_DIV, S_MUL1, S_MUL2, S_NUM, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_AVG0, OP_AVG1, OP_AVG2, OP_U, OP_W, OP_LIFT
  } op_e;

  function automatic coord_t sat16(logic signed [DivW-1:0] v);
    if (v > 64'sd32767) return coord_t'(16'sh7fff);
    if (v < -64'sd32768) return coord_t'(16'sh8000);
    return coord_t'(v[CoordW-1:0]);
  endfunction

  function automatic logic [NormW-1:0] mag_n(logic signed [NormW-1:0] v);
    return v[NormW-1] ? NormW'(-v) : NormW'(v);
  endfunction

  function automatic logic [AreaW-1:0] mag_a(logic signed [AreaW-1:0] v);
    return v[AreaW-1] ? AreaW'(-v) : AreaW'(v);
  endfunction

  // in-plane axes of the plane that drops axis p
  function automatic logic [1:0] u_axis(logic [1:0] p);
    return (p == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] v_axis(logic [1:0] p);
    return (p == 2'd2) ? 2'd1 : 2'd2;
  endfunction

endpackage

// ===== rtl/polygon_centroid_newell.sv =====
// top level of the polygon centroid block
// Vertices enter one item at a time on the s_axis channel (x, y, z in tdata,
// tlast on the polygon's final vertex). Each item goes into a small queue,
// and the engine behind it works out the edge sums of each vertex (edge
// products, then accumulation), taking no new vertex until they are done.
// After the last vertex come the closing edge and axis selection, and then
// the shared 64-bit divider (one quotient bit a cycle) runs 3 divisions for
// the vertex average, or 3 divisions with two multiplies before the last
// for the area centroid; the first-vertex result needs no division.
// One result item per polygon, registered on m_axis; while the receiver
// stalls the finished result holds and the queue keeps taking vertices.
// Thresholds are written on the cfg port (index 0 area, 1 normal); the user
// must write them only while idle, which the block does not enforce. Reset
// empties the queue, clears all polygon sums and sets both thresholds to 1.
module polygon_centroid_newell import pcn_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int QueueDepth   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DataInW-1:0]  s_axis_tdata,   // vx, vy, vz
  input  logic                s_axis_tlast,   // last_vertex
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DataOutW-1:0] m_axis_tdata,   // cent_x, cent_y, cent_z, status, zero pad
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [ThrW-1:0]     cfg_data_i
);

  logic [ThrW-1:0] area_thr_q, norm_thr_q;
  vtx_t in_item, q_item;
  logic q_valid, q_ready;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_thr_q <= ThrW'(1);
      norm_thr_q <= ThrW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_AREA_THR: area_thr_q <= cfg_data_i;
        REG_NORM_THR: norm_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.vx   = s_axis_tdata[15:0];
  assign in_item.vy   = s_axis_tdata[31:16];
  assign in_item.vz   = s_axis_tdata[47:32];
  assign in_item.last = s_axis_tlast;

  pcn_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  pcn_back #(
    .MaxVertices (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .area_thr_i  (area_thr_q),
    .norm_thr_i  (norm_thr_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {6'b0, res.status, res.cz, res.cy, res.cx};

endmodule

// ===== rtl/pcn_front.sv =====
// input queue that decouples vertex intake from the accumulate and finish engine
module pcn_front import pcn_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  vtx_t in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output vtx_t out_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vtx_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// ===== rtl/pcn_div.sv =====
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module pcn_div import pcn_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DivW-1:0] dividend_i,
  input  logic signed [DivW-1:0] divisor_i,
  output logic                   done_o,
  output logic signed [DivW-1:0] quot_o
);

  localparam int StepW = $clog2(DivW);

  logic busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]  quo_q, quo_d, dvs_q, dvs_d;
  logic [DivW:0]    shifted, trial;

  assign shifted = {rem_q[DivW-1:0], quo_q[DivW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign done_o  = done_q;
  assign quot_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DivW-1] ? DivW'(-dividend_i) : DivW'(dividend_i);
      dvs_d  = divisor_i[DivW-1] ? DivW'(-divisor_i) : DivW'(divisor_i);
      neg_d  = dividend_i[DivW-1] ^ divisor_i[DivW-1];
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

// ===== rtl/pcn_back.sv =====
// accumulation of edge sums and the closing centroid sequence
module pcn_back import pcn_pkg::*; #(
  parameter int MaxVertices = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vtx_t            in_item_i,
  input  logic [ThrW-1:0] area_thr_i,
  input  logic [ThrW-1:0] norm_thr_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output res_t            out_res_o
);

  localparam int CntW = $clog2(MaxVertices + 1);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   last_q, last_d, closing_q, closing_d, ovf_q, ovf_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  coord_t first_q [3], first_d [3];
  coord_t prev_q [3], prev_d [3];
  coord_t ea_q [3], ea_d [3], eb_q [3], eb_d [3];
  coord_t vin [3];
  logic signed [2*CoordW+1:0] nt_q [3], nt_d [3];
  logic signed [2*CoordW:0]   cr_q [3], cr_d [3];
  logic signed [CoordW:0]     su_q [3], su_d [3], sv_q [3], sv_d [3];
  logic signed [NormW-1:0] nsum_q [3], nsum_d [3];
  logic signed [AreaW-1:0] asum_q [3], asum_d [3];
  logic signed [MomW-1:0]  msum_q [6], msum_d [6];
  logic signed [SumW-1:0]  csum_q [3], csum_d [3];

  logic [1:0] d_q, d_d, iu_w, iv_w;
  coord_t u_q, u_d, w_q, w_d;
  logic signed [DivW-1:0] p1_q, p1_d, p2_q, p2_d;
  coord_t  res_q [3], res_d [3];
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;
  res_t    out_res_q, out_res_d;

  logic [NormW-1:0] ax, ay, az, nmag;
  logic [AreaW-1:0] amag;
  logic signed [AreaW+1:0] den_w;
  logic over_w, out_free;

  logic div_start, div_done;
  logic signed [DivW-1:0] div_a, div_b, div_q;

  pcn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign vin[0]   = in_item_i.vx;
  assign vin[1]   = in_item_i.vy;
  assign vin[2]   = in_item_i.vz;
  assign iu_w     = u_axis(d_q);
  assign iv_w     = v_axis(d_q);
  assign ax       = mag_n(nsum_q[0]);
  assign ay       = mag_n(nsum_q[1]);
  assign az       = mag_n(nsum_q[2]);
  assign nmag     = mag_n(nsum_q[d_q]);
  assign amag     = mag_a(asum_q[d_q]);
  assign den_w    = asum_q[d_q] + asum_q[d_q] + asum_q[d_q];
  assign over_w   = ovf_q || (cnt_q >= CntW'(MaxVertices));
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (over_w) begin
            state_d = in_item_i.last ? S_OUT : S_IDLE;
          end else if (cnt_q == '0) begin
            state_d = in_item_i.last ? S_E1 : S_IDLE;
          end else begin
            state_d = S_E1;
          end
        end
      end
      S_E1: state_d = S_E2;
      S_E2: begin
        if (closing_q) state_d = S_PICK;
        else if (last_q) state_d = S_E1;
        else state_d = S_IDLE;
      end
      S_PICK: state_d = S_SEL;
      S_SEL: begin
        if (amag <= {2'b0, area_thr_i}) state_d = S_DIV;
        else if (nmag <= {3'b0, norm_thr_i}) state_d = S_OUT;
        else state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (op_q == OP_AVG2 || op_q == OP_LIFT) state_d = S_OUT;
          else if (op_q == OP_W) state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_NUM;
      S_NUM:  state_d = S_DIV;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and sequencer outputs
  always_comb begin
    int i1, i2, iu, iv;
    op_d      = op_q;
    last_d    = last_q;
    closing_d = closing_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    prev_d    = prev_q;
    ea_d      = ea_q;
    eb_d      = eb_q;
    nsum_d    = nsum_q;
    asum_d    = asum_q;
    msum_d    = msum_q;
    csum_d    = csum_q;
    d_d       = d_q;
    u_d       = u_q;
    w_d       = w_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    res_d     = res_q;
    status_d  = status_q;
    out_res_d = out_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;

    // edge products, consumed in the following cycle
    for (int k = 0; k < 3; k++) begin
      i1 = (k == 2) ? 0 : k + 1;
      i2 = (k == 0) ? 2 : k - 1;
      iu = (k == 0) ? 1 : 0;
      iv = (k == 2) ? 1 : 2;
      nt_d[k] = (ea_q[i1] - eb_q[i1]) * (ea_q[i2] + eb_q[i2]);
      cr_d[k] = ea_q[iu] * eb_q[iv] - eb_q[iu] * ea_q[iv];
      su_d[k] = ea_q[iu] + eb_q[iu];
      sv_d[k] = ea_q[iv] + eb_q[iv];
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = in_item_i.last;
          if (over_w) begin
            ovf_d = 1'b1;
            if (in_item_i.last) begin
              for (int k = 0; k < 3; k++) res_d[k] = '0;
              status_d = ST_OVF;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
            for (int k = 0; k < 3; k++) begin
              csum_d[k] = csum_q[k] + vin[k];
              prev_d[k] = vin[k];
            end
            if (cnt_q == '0) begin
              first_d = vin;
              // single vertex: self edge adds nothing
              ea_d = vin;
              eb_d = vin;
              closing_d = 1'b1;
            end else begin
              ea_d = prev_q;
              eb_d = vin;
              closing_d = 1'b0;
            end
          end
        end
      end
      S_E2: begin
        for (int k = 0; k < 3; k++) begin
          nsum_d[k]       = nsum_q[k] + nt_q[k];
          asum_d[k]       = asum_q[k] + cr_q[k];
          msum_d[2*k]     = msum_q[2*k] + su_q[k] * cr_q[k];
          msum_d[2*k + 1] = msum_q[2*k + 1] + sv_q[k] * cr_q[k];
        end
        if (!closing_q && last_q) begin
          ea_d = prev_q;
          eb_d = first_q;
          closing_d = 1'b1;
        end
      end
      S_PICK: begin
        // ties prefer x, then y
        if (ax >= ay && ax >= az) d_d = 2'd0;
        else if (ay >= az) d_d = 2'd1;
        else d_d = 2'd2;
      end
      S_SEL: begin
        if (amag <= {2'b0, area_thr_i}) begin
          status_d  = ST_AVG;
          op_d      = OP_AVG0;
          div_start = 1'b1;
          div_a     = DivW'(csum_q[0]);
          div_b     = DivW'(cnt_q);
        end else if (nmag <= {3'b0, norm_thr_i}) begin
          res_d    = first_q;
          status_d = ST_FIRST;
        end else begin
          op_d      = OP_U;
          div_start = 1'b1;
          div_a     = DivW'(msum_q[{d_q, 1'b0}]);
          div_b     = DivW'(den_w);
        end
      end
      S_DIV: begin
        if (div_done) begin
          case (op_q)
            OP_AVG0: begin
              res_d[0]  = sat16(div_q);
              op_d      = OP_AVG1;
              div_start = 1'b1;
              div_a     = DivW'(csum_q[1]);
              div_b     = DivW'(cnt_q);
            end
            OP_AVG1: begin
              res_d[1]  = sat16(div_q);
              op_d      = OP_AVG2;
              div_start = 1'b1;
              div_a     = DivW'(csum_q[2]);
              div_b     = DivW'(cnt_q);
            end
            OP_AVG2: res_d[2] = sat16(div_q);
            OP_U: begin
              u_d       = sat16(div_q);
              op_d      = OP_W;
              div_start = 1'b1;
              div_a     = DivW'(msum_q[{d_q, 1'b1}]);
              div_b     = DivW'(den_w);
            end
            OP_W: w_d = sat16(div_q);
            OP_LIFT: begin
              for (int k = 0; k < 3; k++) begin
                if (2'(k) == d_q) res_d[k] = sat16(first_q[k] - div_q);
                else if (2'(k) == iu_w) res_d[k] = u_q;
                else res_d[k] = w_q;
              end
              status_d = ST_AREA;
            end
            default: ;
          endcase
        end
      end
      S_MUL1: p1_d = nsum_q[iu_w] * (u_q - first_q[iu_w]);
      S_MUL2: p2_d = nsum_q[iv_w] * (w_q - first_q[iv_w]);
      S_NUM: begin
        op_d      = OP_LIFT;
        div_start = 1'b1;
        div_a     = p1_q + p2_q;
        div_b     = DivW'(nsum_q[d_q]);
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_res_d.cx     = res_q[0];
          out_res_d.cy     = res_q[1];
          out_res_d.cz     = res_q[2];
          out_res_d.status = status_q;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          last_d    = 1'b0;
          closing_d = 1'b0;
          for (int k = 0; k < 3; k++) begin
            nsum_d[k] = '0;
            asum_d[k] = '0;
            csum_d[k] = '0;
          end
          for (int k = 0; k < 6; k++) msum_d[k] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_AVG0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        nsum_q[k] <= '0;
        asum_q[k] <= '0;
        csum_q[k] <= '0;
      end
      for (int k = 0; k < 6; k++) msum_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      last_q      <= last_d;
      closing_q   <= closing_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      nsum_q      <= nsum_d;
      asum_q      <= asum_d;
      csum_q      <= csum_d;
      msum_q      <= msum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    prev_q    <= prev_d;
    ea_q      <= ea_d;
    eb_q      <= eb_d;
    nt_q      <= nt_d;
    cr_q      <= cr_d;
    su_q      <= su_d;
    sv_q      <= sv_d;
    d_q       <= d_d;
    u_q       <= u_d;
    w_q       <= w_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    res_q     <= res_d;
    status_q  <= status_d;
    out_res_q <= out_res_d;
  end

endmodule

// ===== verif/pcn_checker.sv =====
// checker for the polygon centroid block: predicts each centroid result and compares it
`timescale 1ns / 1ps

module pcn_checker import pcn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [DataInW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [DataOutW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [ThrW-1:0]     cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int MAX_VERTICES_C = 256;

  typedef struct {
    coord_t  cx;
    coord_t  cy;
    coord_t  cz;
    status_e status;
  } centroid_t;

  centroid_t centroid_q[$];

  logic [ThrW-1:0] area_thr, norm_thr;
  longint first_v[3], prev_v[3], normal[3], area_sum[3], moment[6], coord_sum[3];
  int     n_vertices;
  bit     too_many;

  assign pending_o = centroid_q.size();

  function automatic int axis_u(int p);
    return (p == 0) ? 1 : 0;
  endfunction

  function automatic int axis_v(int p);
    return (p == 2) ? 1 : 2;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_polygon();
    for (int k = 0; k < 3; k++) begin
      first_v[k] = 0; prev_v[k] = 0; normal[k] = 0; area_sum[k] = 0; coord_sum[k] = 0;
    end
    for (int k = 0; k < 6; k++) moment[k] = 0;
    n_vertices = 0;
    too_many = 0;
  endfunction

  function automatic void add_edge(longint a[3], longint b[3]);
    longint cr;
    for (int k = 0; k < 3; k++)
      normal[k] += (a[(k+1)%3] - b[(k+1)%3]) * (a[(k+2)%3] + b[(k+2)%3]);
    for (int k = 0; k < 3; k++) begin
      cr = a[axis_u(k)] * b[axis_v(k)] - b[axis_u(k)] * a[axis_v(k)];
      area_sum[k] += cr;
      moment[2*k]   += (a[axis_u(k)] + b[axis_u(k)]) * cr;
      moment[2*k+1] += (a[axis_v(k)] + b[axis_v(k)]) * cr;
    end
  endfunction

  // one vertex item; returns 1 when it closes a polygon
  function automatic bit take_vertex(longint v[3], bit last, output centroid_t r);
    longint c[3];
    longint area, den, u, w, nd, num;
    int d;
    status_e st;
    if (too_many || n_vertices >= MAX_VERTICES_C) too_many = 1;
    else begin
      if (n_vertices == 0) first_v = v;
      else add_edge(prev_v, v);
      prev_v = v;
      for (int k = 0; k < 3; k++) coord_sum[k] += v[k];
      n_vertices++;
    end
    if (!last) return 0;
    c = '{0, 0, 0};
    if (too_many || n_vertices == 0) st = ST_OVF;
    else begin
      add_edge(prev_v, first_v);
      if (abs64(normal[0]) >= abs64(normal[1]) && abs64(normal[0]) >= abs64(normal[2])) d = 0;
      else if (abs64(normal[1]) >= abs64(normal[2])) d = 1;
      else d = 2;
      area = area_sum[d];
      if (abs64(area) <= longint'(area_thr)) begin
        for (int k = 0; k < 3; k++) c[k] = coord_sum[k] / longint'(n_vertices);
        st = ST_AVG;
      end else begin
        den = 3 * area;
        u = clip16(moment[2*d] / den);
        w = clip16(moment[2*d+1] / den);
        nd = normal[d];
        if (abs64(nd) <= longint'(norm_thr)) begin
          c = first_v;
          st = ST_FIRST;
        end else begin
          num = normal[axis_u(d)] * (u - first_v[axis_u(d)])
              + normal[axis_v(d)] * (w - first_v[axis_v(d)]);
          c[axis_u(d)] = u;
          c[axis_v(d)] = w;
          c[d] = first_v[d] - num / nd;
          st = ST_AREA;
        end
      end
    end
    r.cx = coord_t'(clip16(c[0]));
    r.cy = coord_t'(clip16(c[1]));
    r.cz = coord_t'(clip16(c[2]));
    r.status = st;
    clear_polygon();
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint v[3];
    centroid_t r, e;
    if (!rst_ni) begin
      area_thr = ThrW'(1);
      norm_thr = ThrW'(1);
      clear_polygon();
      centroid_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_AREA_THR) area_thr = cfg_data_i;
        else norm_thr = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        v[0] = longint'($signed(s_axis_tdata[15:0]));
        v[1] = longint'($signed(s_axis_tdata[31:16]));
        v[2] = longint'($signed(s_axis_tdata[47:32]));
        if (take_vertex(v, s_axis_tlast, r)) centroid_q = {centroid_q, r};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        r.cx = m_axis_tdata[15:0];
        r.cy = m_axis_tdata[31:16];
        r.cz = m_axis_tdata[47:32];
        r.status = status_e'(m_axis_tdata[49:48]);
        if (centroid_q.size() == 0) begin
          $display("%0t: unexpected centroid item x=%0d y=%0d z=%0d status=%0d",
                   $time, r.cx, r.cy, r.cz, r.status);
          fail_count_o++;
        end else begin
          e = centroid_q.pop_front();
          if (r.cx !== e.cx) begin
            $display("%0t: cent_x expected %0d actual %0d", $time, e.cx, r.cx);
            fail_count_o++;
          end
          if (r.cy !== e.cy) begin
            $display("%0t: cent_y expected %0d actual %0d", $time, e.cy, r.cy);
            fail_count_o++;
          end
          if (r.cz !== e.cz) begin
            $display("%0t: cent_z expected %0d actual %0d", $time, e.cz, r.cz);
            fail_count_o++;
          end
          if (r.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_polygon_centroid_newell.sv =====
// testbench top for the polygon centroid block: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module tb_polygon_centroid_newell;
  import pcn_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataInW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DataOutW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = 1'b0;
  logic [ThrW-1:0]     cfg_data_i = '0;

  int  fail_count, pending;
  bit  no_idle = 0;
  bit  hold_off_req = 0;
  int  cycles = 0;

  localparam logic [ThrW-1:0] ThrMax = '1;
  localparam int CycleLimit = 2000000;

  always #5 clk_i = ~clk_i;

  polygon_centroid_newell u_dut (.*);

  pcn_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls per item, one long hold-off on request
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 13);
      if (hold_off_req) begin
        w = 1500;
        hold_off_req = 0;
      end
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_vertex(int x, int y, int z, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {16'(z), 16'(y), 16'(x)};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drain, let the engine finish any trailing work, then write one register
  task automatic write_thr(cfg_reg_e idx, logic [ThrW-1:0] val);
    if (s_axis_tvalid) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic tri3(int ax, int ay, int az, int bx, int by, int bz,
                      int cx, int cy, int cz);
    send_vertex(ax, ay, az, 0);
    send_vertex(bx, by, bz, 0);
    send_vertex(cx, cy, cz, 1);
  endtask

  function automatic int rnd_coord(int mode);
    case (mode)
      0:       return int'($urandom_range(0, 100)) - 50;
      1:       return int'($urandom_range(0, 4000)) - 2000;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // random polygon: a planar outline in one mode of four, random coordinates at three scales otherwise
  task automatic rnd_polygon(int n);
    int mode, px, py, pz, a1, a2, a3, b1, b2, b3, s, t;
    mode = $urandom_range(0, 3);
    px = rnd_coord(2) / 4; py = rnd_coord(2) / 4; pz = rnd_coord(2) / 4;
    a1 = $urandom_range(0, 40) - 20; a2 = $urandom_range(0, 40) - 20;
    a3 = $urandom_range(0, 40) - 20; b1 = $urandom_range(0, 40) - 20;
    b2 = $urandom_range(0, 40) - 20; b3 = $urandom_range(0, 40) - 20;
    for (int i = 0; i < n; i++) begin
      if (mode == 3) begin
        s = $urandom_range(0, 400) - 200;
        t = $urandom_range(0, 400) - 200;
        send_vertex(px + s*a1 + t*b1, py + s*a2 + t*b2, pz + s*a3 + t*b3, i == n-1);
      end else begin
        send_vertex(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), i == n-1);
      end
    end
  endtask

  task automatic rnd_phase(int n_vertices);
    int sent, n;
    sent = 0;
    while (sent < n_vertices) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      rnd_polygon(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single vertex, two vertices, triangles in each plane, degenerate,
    // saturating extremes, tilted quad
    send_vertex(32767, -32768, 0, 1);
    send_vertex(-32768, -32768, -32768, 0);
    send_vertex(32767, 32767, 32767, 1);
    tri3(0, 0, 5, 300, 0, 5, 0, 300, 5);
    tri3(7, 0, 0, 7, 0, 300, 7, 300, 0);
    tri3(0, -9, 0, 0, -9, 300, 300, -9, 0);
    tri3(0, 0, 0, 10, 10, 10, 20, 20, 20);
    tri3(-32768, -32768, 0, 32767, -32768, 100, -32768, 32767, -200);
    tri3(32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768);
    send_vertex(0, 0, 0, 0);
    send_vertex(100, 0, 33, 0);
    send_vertex(100, 100, 66, 0);
    send_vertex(0, 100, 33, 1);

    // thresholds at the bottom
    write_thr(REG_AREA_THR, '0);
    write_thr(REG_NORM_THR, '0);
    tri3(0, 0, 0, 1, 0, 0, 0, 1, 0);
    rnd_phase(150);

    // first-vertex case: area above its threshold, normal at or below its own
    write_thr(REG_AREA_THR, ThrW'(10));
    write_thr(REG_NORM_THR, 40'd1 << 32);
    hold_off_req = 1;
    rnd_phase(150);

    // thresholds at the top, no idling on either side
    write_thr(REG_AREA_THR, ThrMax);
    write_thr(REG_NORM_THR, ThrMax);
    no_idle = 1;
    rnd_phase(80);
    no_idle = 0;

    // too many vertices
    write_thr(REG_AREA_THR, ThrW'($urandom_range(0, 5000)));
    write_thr(REG_NORM_THR, ThrW'($urandom_range(0, 5000)));
    for (int i = 0; i < 258; i++) send_vertex($urandom(), $urandom(), $urandom(), i == 257);
    rnd_phase(150);

    write_thr(REG_AREA_THR, ThrW'(1));
    write_thr(REG_NORM_THR, ThrW'(1));
    rnd_phase(200);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
